/* hw/rtl/ppm_bsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P6 stream parser package
// Shared types, character codes and sizes for the P6 image stream parser.
// ----------------------------------------------------------------------------
package ppm_bsp_pkg;

  localparam int unsigned MAX_DIM_DEF = 4096;
  localparam int unsigned ACC_W       = 17;
  localparam int unsigned ACCX_W      = ACC_W + 4;
  localparam int unsigned IMG_W       = 13;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned DEPTH_LIMIT = 65535;
  localparam int unsigned MID_DEPTH   = 2;
  localparam int unsigned OUT_DEPTH   = 2;

  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_SIX   = 8'h36;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_SIG   = 2'd2,
    ERR_FIELD = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    PH_SIG_P       = 4'd0,
    PH_SIG_6       = 4'd1,
    PH_SIG_WS      = 4'd2,
    PH_OPT_COMMENT = 4'd3,
    PH_COMMENT     = 4'd4,
    PH_WIDTH       = 4'd5,
    PH_HEIGHT      = 4'd6,
    PH_DEPTH       = 4'd7,
    PH_PIXELS      = 4'd8,
    PH_DONE        = 4'd9,
    PH_ERROR       = 4'd10
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       start;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_space;
    logic       is_p;
    logic       is_six;
    logic       is_hash;
    logic       is_nl;
  } cls_t;

  typedef struct packed {
    kind_e              kind;
    err_e               error_code;
    logic [IMG_W-1:0]   image_width;
    logic [IMG_W-1:0]   image_height;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } res_t;

endpackage

/* hw/rtl/ppm_bsp_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P6 image stream parser
// Parses a binary P6 image byte stream into a header item and pixel items.
// ----------------------------------------------------------------------------
// The parser takes one byte item per clock cycle while the result queue is not
// full: every byte is handled by one step of the header state machine in the
// back end, which writes any result item into the result queue in the same
// cycle that it takes the byte from the first queue. A front end
// classifies each byte and places it in a two-entry queue; the back end
// parses and writes results into a two-entry result queue, so a stalled
// consumer holds up the input only once both queues are full. Errors leave
// the parser idle until an item arrives with start_file_i set.
module ppm_binary_stream_parser_top import ppm_bsp_pkg::*; #(
  parameter int unsigned MaxDim = MAX_DIM_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_file_i,
  input  logic               start_file_i,
  input  logic               pop,
  output logic               empty,
  output logic [1:0]         kind_o,
  output logic [1:0]         error_code_o,
  output logic [IMG_W-1:0]   image_width_o,
  output logic [IMG_W-1:0]   image_height_o,
  output logic [COLOR_W-1:0] red_o,
  output logic [COLOR_W-1:0] green_o,
  output logic [COLOR_W-1:0] blue_o,
  output logic               last_o
);

  cls_t cls_in, cls_mid;
  res_t res_back, res_out;
  logic mid_empty, mid_pop;
  logic res_full, res_push;

  ppm_bsp_front u_front (
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .start_file_i  (start_file_i),
    .cls_o         (cls_in)
  );

  ppm_bsp_fifo #(
    .item_t (cls_t),
    .Depth  (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (cls_mid),
    .empty_o (mid_empty)
  );

  ppm_bsp_back #(
    .MaxDim (MaxDim)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (!mid_empty),
    .cls_i       (cls_mid),
    .cls_pop_o   (mid_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_back)
  );

  ppm_bsp_fifo #(
    .item_t (res_t),
    .Depth  (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_back),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign kind_o         = res_out.kind;
  assign error_code_o   = res_out.error_code;
  assign image_width_o  = res_out.image_width;
  assign image_height_o = res_out.image_height;
  assign red_o          = res_out.red;
  assign green_o        = res_out.green;
  assign blue_o         = res_out.blue;
  assign last_o         = res_out.last;

endmodule

/* hw/rtl/ppm_bsp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P6 stream parser front end
// Classifies each incoming byte into the character classes the parser needs.
// ----------------------------------------------------------------------------
module ppm_bsp_front import ppm_bsp_pkg::*; (
  input  logic [7:0] data_byte_i,
  input  logic       end_of_file_i,
  input  logic       start_file_i,
  output cls_t       cls_o
);

  logic [7:0] rel;

  assign rel = data_byte_i - CHAR_ZERO;

  always_comb begin
    cls_o          = '0;
    cls_o.data     = data_byte_i;
    cls_o.eof      = end_of_file_i;
    cls_o.start    = start_file_i;
    cls_o.is_digit = (data_byte_i >= CHAR_ZERO) && (data_byte_i <= CHAR_NINE);
    cls_o.digit    = rel[3:0];
    cls_o.is_space = (data_byte_i == CHAR_SPACE) ||
                     ((data_byte_i >= CHAR_TAB) && (data_byte_i <= CHAR_CR));
    cls_o.is_p     = (data_byte_i == CHAR_P);
    cls_o.is_six   = (data_byte_i == CHAR_SIX);
    cls_o.is_hash  = (data_byte_i == CHAR_HASH);
    cls_o.is_nl    = (data_byte_i == CHAR_NL);
  end

endmodule

/* hw/rtl/ppm_bsp_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P6 stream parser queue
// Small first-in first-out queue used between the parser stages.
// ----------------------------------------------------------------------------
module ppm_bsp_fifo import ppm_bsp_pkg::*; #(
  parameter type         item_t = cls_t,
  parameter int unsigned Depth  = MID_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CNT_W = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(Depth))
    else $error("queue count exceeds its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("queue count did not follow a lone push");

endmodule

/* hw/rtl/ppm_bsp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P6 stream parser back end
// Runs the header state machine and the pixel assembly on classified items.
// ----------------------------------------------------------------------------
module ppm_bsp_back import ppm_bsp_pkg::*; #(
  parameter int unsigned MaxDim = MAX_DIM_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cls_valid_i,
  input  cls_t cls_i,
  output logic cls_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  localparam int unsigned DIM_W = $clog2(MaxDim + 1);
  localparam int unsigned PIX_W = 2 * DIM_W;
  localparam logic [ACCX_W-1:0] DimLimit   = ACCX_W'(MaxDim);
  localparam logic [ACCX_W-1:0] DepthLimit = ACCX_W'(DEPTH_LIMIT);

  phase_e             phase_q, phase_d, eff_phase, num_phase;
  logic [ACC_W-1:0]   acc_q, acc_d, eff_acc;
  logic               seen_q, seen_d, eff_seen;
  logic [DIM_W-1:0]   width_q, width_d, height_q, height_d;
  logic [PIX_W-1:0]   left_q, left_d, pix_total;
  logic [1:0]         bip_q, bip_d;
  logic [COLOR_W-1:0] red_q, red_d, green_q, green_d;
  logic [ACCX_W-1:0]  acc_x, acc_v;
  logic               step, over, prod_zero;
  logic               err_raise, dig_ok, commit_w, commit_h, hdr, pix_byte;
  err_e               err_code;

  assign step      = cls_valid_i && !res_full_i;
  assign cls_pop_o = step;

  assign eff_phase = cls_i.start ? PH_SIG_P : phase_q;
  assign eff_acc   = cls_i.start ? '0 : acc_q;
  assign eff_seen  = cls_i.start ? 1'b0 : seen_q;
  assign num_phase = (eff_phase == PH_OPT_COMMENT) ? PH_WIDTH : eff_phase;

  assign acc_x     = ACCX_W'(eff_acc);
  assign acc_v     = (acc_x << 3) + (acc_x << 1) + ACCX_W'(cls_i.digit);
  assign over      = acc_v > ((num_phase == PH_DEPTH) ? DepthLimit : DimLimit);
  assign pix_total = PIX_W'(width_q) * PIX_W'(height_q);
  assign prod_zero = (width_q == '0) || (height_q == '0);

  always_comb begin
    phase_d   = phase_q;
    err_raise = 1'b0;
    err_code  = ERR_NONE;
    dig_ok    = 1'b0;
    commit_w  = 1'b0;
    commit_h  = 1'b0;
    hdr       = 1'b0;
    pix_byte  = 1'b0;
    if (step) begin
      phase_d = eff_phase;
      priority if (eff_phase == PH_ERROR || eff_phase == PH_DONE) begin
        phase_d = eff_phase;
      end else if (cls_i.eof) begin
        err_raise = 1'b1;
        err_code  = ERR_TRUNC;
      end else begin
        unique case (eff_phase)
          PH_SIG_P: begin
            if (cls_i.is_p) phase_d = PH_SIG_6;
            else begin
              err_raise = 1'b1;
              err_code  = ERR_SIG;
            end
          end
          PH_SIG_6: begin
            if (cls_i.is_six) phase_d = PH_SIG_WS;
            else begin
              err_raise = 1'b1;
              err_code  = ERR_SIG;
            end
          end
          PH_SIG_WS: begin
            if (cls_i.is_space) phase_d = PH_OPT_COMMENT;
            else begin
              err_raise = 1'b1;
              err_code  = ERR_SIG;
            end
          end
          PH_COMMENT: begin
            if (cls_i.is_nl) phase_d = PH_WIDTH;
          end
          PH_OPT_COMMENT, PH_WIDTH, PH_HEIGHT, PH_DEPTH: begin
            if ((eff_phase == PH_OPT_COMMENT) && cls_i.is_hash) begin
              phase_d = PH_COMMENT;
            end else begin
              phase_d = num_phase;
              if (cls_i.is_digit) begin
                if (over) begin
                  err_raise = 1'b1;
                  err_code  = ERR_FIELD;
                end else begin
                  dig_ok = 1'b1;
                end
              end else if (!cls_i.is_space) begin
                err_raise = 1'b1;
                err_code  = ERR_FIELD;
              end else if (eff_seen) begin
                unique case (num_phase)
                  PH_WIDTH: begin
                    commit_w = 1'b1;
                    phase_d  = PH_HEIGHT;
                  end
                  PH_HEIGHT: begin
                    commit_h = 1'b1;
                    phase_d  = PH_DEPTH;
                  end
                  default: begin
                    if (cls_i.is_nl) begin
                      hdr     = 1'b1;
                      phase_d = prod_zero ? PH_DONE : PH_PIXELS;
                    end else begin
                      err_raise = 1'b1;
                      err_code  = ERR_FIELD;
                    end
                  end
                endcase
              end
            end
          end
          PH_PIXELS: begin
            pix_byte = 1'b1;
            if ((bip_q == 2'd2) && (left_q == PIX_W'(1))) phase_d = PH_DONE;
          end
          default: phase_d = eff_phase;
        endcase
      end
      if (err_raise) phase_d = PH_ERROR;
    end
  end

  always_comb begin
    acc_d      = acc_q;
    seen_d     = seen_q;
    width_d    = width_q;
    height_d   = height_q;
    left_d     = left_q;
    bip_d      = bip_q;
    red_d      = red_q;
    green_d    = green_q;
    res_push_o = 1'b0;
    res_o      = '0;
    if (step) begin
      acc_d  = eff_acc;
      seen_d = eff_seen;
      if (dig_ok) begin
        acc_d  = acc_v[ACC_W-1:0];
        seen_d = 1'b1;
      end
      if (commit_w || commit_h || hdr) begin
        acc_d  = '0;
        seen_d = 1'b0;
      end
      if (commit_w) width_d = DIM_W'(eff_acc);
      if (commit_h) height_d = DIM_W'(eff_acc);
      if (hdr) begin
        left_d             = pix_total;
        bip_d              = 2'd0;
        res_push_o         = 1'b1;
        res_o.kind         = KIND_HEADER;
        res_o.error_code   = ERR_NONE;
        res_o.image_width  = IMG_W'(width_q);
        res_o.image_height = IMG_W'(height_q);
        res_o.last         = prod_zero;
      end
      if (pix_byte) begin
        unique case (bip_q)
          2'd0: begin
            red_d = cls_i.data;
            bip_d = 2'd1;
          end
          2'd1: begin
            green_d = cls_i.data;
            bip_d   = 2'd2;
          end
          default: begin
            bip_d              = 2'd0;
            left_d             = left_q - PIX_W'(1);
            res_push_o         = 1'b1;
            res_o.kind         = KIND_PIXEL;
            res_o.error_code   = ERR_NONE;
            res_o.image_width  = IMG_W'(width_q);
            res_o.image_height = IMG_W'(height_q);
            res_o.red          = red_q;
            res_o.green        = green_q;
            res_o.blue         = cls_i.data;
            res_o.last         = (left_q == PIX_W'(1));
          end
        endcase
      end
      if (err_raise) begin
        res_push_o       = 1'b1;
        res_o            = '0;
        res_o.kind       = KIND_ERROR;
        res_o.error_code = err_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SIG_P;
      acc_q    <= '0;
      seen_q   <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      left_q   <= '0;
      bip_q    <= 2'd0;
    end else begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      seen_q   <= seen_d;
      width_q  <= width_d;
      height_q <= height_d;
      left_q   <= left_d;
      bip_q    <= bip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && (res_o.kind == KIND_ERROR)) |=> (phase_q == PH_ERROR))
    else $error("error item issued without entering the error phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXELS) |-> (left_q != '0))
    else $error("pixel phase with no pixels left");

endmodule

/* tb/sv/ppm_binary_stream_parser_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P6 image stream parser testbench
// Streams directed and random P6 files, some well formed and some broken, into
// the parser under random input gaps and output stalls. Every result item is
// checked field by field against a cycle-free model of the header and pixel
// parsing held in the testbench.
// ----------------------------------------------------------------------------
module ppm_binary_stream_parser_top_tb;
  import ppm_bsp_pkg::*;

  localparam int unsigned MAX_SIDE     = MAX_DIM_DEF;
  localparam int          IDLE_LIMIT   = 4000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          RANDOM_ITEMS = 650;
  localparam int          DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       start;
  } stim_t;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [7:0]         data_byte_i;
  logic               end_of_file_i;
  logic               start_file_i;
  logic               pop;
  logic               empty;
  logic [1:0]         kind_o;
  logic [1:0]         error_code_o;
  logic [IMG_W-1:0]   image_width_o;
  logic [IMG_W-1:0]   image_height_o;
  logic [COLOR_W-1:0] red_o;
  logic [COLOR_W-1:0] green_o;
  logic [COLOR_W-1:0] blue_o;
  logic               last_o;

  ppm_binary_stream_parser_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .end_of_file_i  (end_of_file_i),
    .start_file_i   (start_file_i),
    .pop            (pop),
    .empty          (empty),
    .kind_o         (kind_o),
    .error_code_o   (error_code_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .last_o         (last_o)
  );

  phase_e      parse_phase;
  int unsigned number_accum;
  bit          digit_seen;
  int unsigned width_reg;
  int unsigned height_reg;
  int unsigned pixels_left;
  int unsigned byte_in_pixel;
  logic [7:0]  held_red;
  logic [7:0]  held_green;

  res_t  expected_results[$];
  res_t  oldest_result;
  stim_t file_q[$];
  int    item_count;
  int    mismatch_count;
  int    stray_count;
  int    report_count;
  int    burst_left;
  bit    steady_sender;
  int    hold_len;

  function automatic void clear_parser();
    parse_phase   = PH_SIG_P;
    number_accum  = 0;
    digit_seen    = 1'b0;
    width_reg     = 0;
    height_reg    = 0;
    pixels_left   = 0;
    byte_in_pixel = 0;
    held_red      = '0;
    held_green    = '0;
  endfunction

  function automatic bit is_ws(logic [7:0] b);
    return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_NL || b == 8'h0B ||
           b == 8'h0C || b == CHAR_CR;
  endfunction

  function automatic logic [7:0] random_ws();
    case ($urandom_range(0, 5))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      2: return CHAR_NL;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return CHAR_CR;
    endcase
  endfunction

  // Advances the parser state by one input item and returns 1 when the item
  // produces a result item.
  function automatic bit parse_step(input logic [7:0] b, input logic eof,
                                    input logic start, output res_t r);
    bit          emit;
    bit          number;
    err_e        bad;
    int unsigned lim;
    int unsigned v;
    emit   = 1'b0;
    number = 1'b0;
    bad    = ERR_NONE;
    r      = '0;
    if (start) clear_parser();
    if (parse_phase == PH_ERROR || parse_phase == PH_DONE) return 1'b0;
    if (eof) begin
      bad = ERR_TRUNC;
    end else begin
      case (parse_phase)
        PH_SIG_P: begin
          if (b == CHAR_P) parse_phase = PH_SIG_6;
          else bad = ERR_SIG;
        end
        PH_SIG_6: begin
          if (b == CHAR_SIX) parse_phase = PH_SIG_WS;
          else bad = ERR_SIG;
        end
        PH_SIG_WS: begin
          if (is_ws(b)) parse_phase = PH_OPT_COMMENT;
          else bad = ERR_SIG;
        end
        PH_OPT_COMMENT: begin
          if (b == CHAR_HASH) begin
            parse_phase = PH_COMMENT;
          end else begin
            parse_phase = PH_WIDTH;
            number      = 1'b1;
          end
        end
        PH_COMMENT: begin
          if (b == CHAR_NL) parse_phase = PH_WIDTH;
        end
        PH_PIXELS: begin
          if (byte_in_pixel == 0) begin
            held_red      = b;
            byte_in_pixel = 1;
          end else if (byte_in_pixel == 1) begin
            held_green    = b;
            byte_in_pixel = 2;
          end else begin
            byte_in_pixel = 0;
            pixels_left--;
            if (pixels_left == 0) parse_phase = PH_DONE;
            r.kind         = KIND_PIXEL;
            r.image_width  = width_reg[IMG_W-1:0];
            r.image_height = height_reg[IMG_W-1:0];
            r.red          = held_red;
            r.green        = held_green;
            r.blue         = b;
            r.last         = (pixels_left == 0);
            emit           = 1'b1;
          end
        end
        default: begin
          number = 1'b1;
        end
      endcase
    end
    if (number) begin
      lim = (parse_phase == PH_DEPTH) ? DEPTH_LIMIT : MAX_SIDE;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
        v = number_accum * 10 + (b - CHAR_ZERO);
        if (v > lim) begin
          bad = ERR_FIELD;
        end else begin
          number_accum = v;
          digit_seen   = 1'b1;
        end
      end else if (!is_ws(b)) begin
        bad = ERR_FIELD;
      end else if (digit_seen) begin
        case (parse_phase)
          PH_WIDTH: begin
            width_reg   = number_accum;
            parse_phase = PH_HEIGHT;
          end
          PH_HEIGHT: begin
            height_reg  = number_accum;
            parse_phase = PH_DEPTH;
          end
          default: begin
            if (b != CHAR_NL) begin
              bad = ERR_FIELD;
            end else begin
              pixels_left   = width_reg * height_reg;
              byte_in_pixel = 0;
              if (pixels_left == 0) parse_phase = PH_DONE;
              else parse_phase = PH_PIXELS;
              r.kind         = KIND_HEADER;
              r.image_width  = width_reg[IMG_W-1:0];
              r.image_height = height_reg[IMG_W-1:0];
              r.last         = (pixels_left == 0);
              emit           = 1'b1;
            end
          end
        endcase
        number_accum = 0;
        digit_seen   = 1'b0;
      end
    end
    if (bad != ERR_NONE) begin
      parse_phase  = PH_ERROR;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = bad;
      emit         = 1'b1;
    end
    return emit;
  endfunction

  function automatic void add_byte(logic [7:0] d);
    stim_t it;
    it.data  = d;
    it.eof   = 1'b0;
    it.start = 1'b0;
    file_q.push_back(it);
  endfunction

  function automatic void add_eof();
    stim_t it;
    it.data  = 8'($urandom);
    it.eof   = 1'b1;
    it.start = 1'b0;
    file_q.push_back(it);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_number(int unsigned v, int zeros);
    for (int i = 0; i < zeros; i++) add_byte(CHAR_ZERO);
    add_text($sformatf("%0d", v));
  endfunction

  function automatic void add_pixels(int n);
    for (int i = 0; i < n; i++) begin
      add_byte(8'($urandom));
      add_byte(8'($urandom));
      add_byte(8'($urandom));
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Offers one item, keeping push high until it is taken.
  task automatic send_item(stim_t it);
    res_t r;
    int   gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        @(negedge clk_i);
        push = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    push          = 1'b1;
    data_byte_i   = it.data;
    end_of_file_i = it.eof;
    start_file_i  = it.start;
    do @(posedge clk_i); while (full);
    item_count++;
    burst_left--;
    if (parse_step(it.data, it.eof, it.start, r)) expected_results.push_back(r);
  endtask

  task automatic send_file(bit restart);
    if (restart && file_q.size() > 0) file_q[0].start = 1'b1;
    foreach (file_q[i]) send_item(file_q[i]);
    file_q.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push       = 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_basic_images();
    add_text("P6\n2 1\n255\n");
    add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
    add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF);
    add_byte(8'h5A);
    add_eof();
    send_file(1'b0);
    add_text("P6 #c\n0 3 1\n");
    add_byte(8'h61);
    send_file(1'b1);
  endtask

  task automatic test_dimension_limits();
    add_text("P6\n4096 0 65535\n");
    send_file(1'b1);
    add_text("P6\t0004097");
    send_file(1'b1);
    add_text("P6\n1 1 65536");
    send_file(1'b1);
  endtask

  task automatic test_bad_signature();
    add_text("QP6");
    add_eof();
    send_file(1'b1);
    add_text("P5");
    send_file(1'b1);
    add_text("P6x");
    send_file(1'b1);
  endtask

  task automatic test_bad_fields();
    add_text("P6 -1");
    send_file(1'b1);
    add_text("P6 1 +2");
    send_file(1'b1);
    add_text("P6 1 1 255 ");
    send_file(1'b1);
    add_text("P6 1 1 255");
    add_byte(CHAR_CR);
    send_file(1'b1);
  endtask

  task automatic test_truncated_file();
    add_text("P6\n1 1 255\n");
    add_byte(8'h12); add_byte(8'h34);
    add_eof();
    send_file(1'b1);
    add_eof();
    send_file(1'b1);
  endtask

  task automatic test_output_stall_backpressure();
    hold_len = HOLD_CYCLES;
    steady_sender = 1'b1;
    add_text("P6\n6 6 255\n");
    add_pixels(36);
    send_file(1'b1);
    wait_drained();
    steady_sender = 1'b0;
  endtask

  task automatic test_random_streams();
    int w;
    int h;
    int depth;
    int hdr_len;
    int sel;
    bit oversize;
    while (item_count < RANDOM_ITEMS) begin
      steady_sender = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 11);
      if (sel == 0) begin
        repeat ($urandom_range(1, 8)) begin
          add_byte(8'($urandom));
          if ($urandom_range(0, 3) == 0) file_q[file_q.size() - 1].start = 1'b1;
          if ($urandom_range(0, 5) == 0) file_q[file_q.size() - 1].eof = 1'b1;
        end
        send_file(1'b0);
      end else begin
        w = ($urandom_range(0, 7) == 0) ? 0 :
            ($urandom_range(0, 15) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        h = ($urandom_range(0, 7) == 0) ? 0 :
            ($urandom_range(0, 15) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        depth = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 255);
        oversize = 1'b0;
        if ($urandom_range(0, 19) == 0) begin
          w = $urandom_range(MAX_SIDE + 1, 9999);
          oversize = 1'b1;
        end else if ($urandom_range(0, 19) == 0) begin
          depth = $urandom_range(65536, 99999);
          oversize = 1'b1;
        end
        add_text("P6");
        add_byte(random_ws());
        if ($urandom_range(0, 2) == 0) begin
          add_byte(CHAR_HASH);
          repeat ($urandom_range(0, 6)) begin
            add_byte(8'($urandom));
            if (file_q[file_q.size() - 1].data == CHAR_NL) file_q[file_q.size() - 1].data = 8'h78;
          end
          add_byte(CHAR_NL);
        end
        repeat ($urandom_range(0, 2)) add_byte(random_ws());
        add_number(w, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
        repeat ($urandom_range(1, 2)) add_byte(random_ws());
        add_number(h, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
        repeat ($urandom_range(1, 2)) add_byte(random_ws());
        add_number(depth, ($urandom_range(0, 4) == 0) ? 1 : 0);
        add_byte(CHAR_NL);
        hdr_len = file_q.size();
        if (!oversize) add_pixels(w * h);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
          if ($urandom_range(0, 1) == 0) add_eof();
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          sel = $urandom_range(1, file_q.size() - 1);
          while (file_q.size() > sel) void'(file_q.pop_back());
          add_eof();
        end else if (sel == 1) begin
          file_q[$urandom_range(0, hdr_len - 1)].data = 8'($urandom);
        end
        send_file($urandom_range(0, 9) != 0);
      end
    end
  endtask

  // Receiver: random stall modes, plus a long hold-off on request.
  initial begin : receiver
    int mode;
    int mode_left;
    int stall_left;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    pop        = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        pop = 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        if (stall_left > 0) begin
          stall_left--;
          pop = 1'b0;
        end else if (mode == 1 && $urandom_range(0, 3) == 0) begin
          stall_left = $urandom_range(0, 2);
          pop = 1'b0;
        end else if (mode == 2 && $urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(3, 12);
          pop = 1'b0;
        end else begin
          pop = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        stray_count++;
        if (report_count < 10) begin
          report_count++;
          $display("%0t: unexpected result kind=%0d err=%0d", $realtime, kind_o,
                   error_code_o);
        end
      end else begin
        oldest_result = expected_results.pop_front();
        if (kind_o !== oldest_result.kind || error_code_o !== oldest_result.error_code ||
            image_width_o !== oldest_result.image_width ||
            image_height_o !== oldest_result.image_height ||
            red_o !== oldest_result.red || green_o !== oldest_result.green ||
            blue_o !== oldest_result.blue || last_o !== oldest_result.last) begin
          mismatch_count++;
          if (report_count < 10) begin
            report_count++;
            $display("%0t: mismatch expected kind=%0d err=%0d w=%0d h=%0d rgb=%h %h %h last=%0b",
                     $realtime, oldest_result.kind, oldest_result.error_code,
                     oldest_result.image_width, oldest_result.image_height,
                     oldest_result.red, oldest_result.green, oldest_result.blue,
                     oldest_result.last);
            $display("%0t:          actual kind=%0d err=%0d w=%0d h=%0d rgb=%h %h %h last=%0b",
                     $realtime, kind_o, error_code_o, image_width_o, image_height_o,
                     red_o, green_o, blue_o, last_o);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) idle = 0;
      else idle++;
    end
    $display("Watchdog expired with %0d results outstanding.", expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    push           = 1'b0;
    data_byte_i    = '0;
    end_of_file_i  = 1'b0;
    start_file_i   = 1'b0;
    rst_ni         = 1'b0;
    item_count     = 0;
    mismatch_count = 0;
    stray_count    = 0;
    report_count   = 0;
    burst_left     = 0;
    steady_sender  = 1'b0;
    hold_len       = 0;
    clear_parser();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_images();
    test_dimension_limits();
    test_bad_signature();
    test_bad_fields();
    test_truncated_file();
    test_output_stall_backpressure();
    test_random_streams();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && stray_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
